FILE: sv/button_click_hold_classifier_core_macros.svh
// assertion macros shared by the button classifier rtl
// expects clk and rst_n in the scope of each use
`ifndef BUTTON_CLICK_HOLD_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_CLICK_HOLD_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication
`define BCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/bcc_pkg.sv
// types and constants for the button click / hold classifier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned CLICK_W    = 8;

  localparam logic [CLICK_W-1:0] CLICK_SAT = '1;

  localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLICK_MAX   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLICK_WIN   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_WARN   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG_HOLD   = 3'd4;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd30;
  localparam logic [CFG_W-1:0] CLICK_MAX_RST = 16'd400;
  localparam logic [CFG_W-1:0] CLICK_WIN_RST = 16'd300;
  localparam logic [CFG_W-1:0] HOLD_WARN_RST = 16'd5000;
  localparam logic [CFG_W-1:0] LONG_HOLD_RST = 16'd9000;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_TRIPLE = 3'd3,
    EV_WARN   = 3'd4,
    EV_LONG   = 3'd5
  } ev_code_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] click_max_ms;
    logic [CFG_W-1:0] click_window_ms;
    logic [CFG_W-1:0] hold_warning_ms;
    logic [CFG_W-1:0] long_hold_ms;
  } bcc_cfg_t;

endpackage

`default_nettype wire

FILE: sv/bcc_if.sv
// valid/ready channel interfaces for poll items and event results
// depends on bcc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bcc_in_if;
  import bcc_pkg::*;
  logic             valid;
  logic             ready;
  logic             button_level;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, output button_level, output now_ms, input ready);
  modport sink (input valid, input button_level, input now_ms, output ready);
endinterface

interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

`default_nettype wire

FILE: sv/bcc_engine.sv
// debounce, click counting and hold detection state for one poll per cycle while step_en is high
// depends on bcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcc_engine
  import bcc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bcc_cfg_t             cfg,
  input  wire logic                 step_en,
  input  wire logic                 level,
  input  wire logic [TIME_BITS-1:0] now,
  output ev_code_t                  ev
);

  logic                 stable_r, stable_nxt;
  logic                 prev_raw_r, prev_raw_nxt;
  logic [TIME_BITS-1:0] change_time_r, change_time_nxt;
  logic [TIME_BITS-1:0] press_time_r, press_time_nxt;
  logic [TIME_BITS-1:0] last_click_r, last_click_nxt;
  logic [CLICK_W-1:0]   click_total_r, click_total_nxt;
  logic                 warn_done_r, warn_done_nxt;

  logic [TIME_BITS-1:0] deb_t, cmax_t, cwin_t, hwarn_t, lhold_t;
  logic [TIME_BITS-1:0] since_change, since_press, since_click, held;

  assign deb_t   = TIME_BITS'(cfg.debounce_ms);
  assign cmax_t  = TIME_BITS'(cfg.click_max_ms);
  assign cwin_t  = TIME_BITS'(cfg.click_window_ms);
  assign hwarn_t = TIME_BITS'(cfg.hold_warning_ms);
  assign lhold_t = TIME_BITS'(cfg.long_hold_ms);

  always_comb begin
    prev_raw_nxt    = level;
    change_time_nxt = (level != prev_raw_r) ? now : change_time_r;
    stable_nxt      = stable_r;
    press_time_nxt  = press_time_r;
    last_click_nxt  = last_click_r;
    click_total_nxt = click_total_r;
    warn_done_nxt   = warn_done_r;
    ev              = EV_NONE;

    // debounce accept
    since_change = now - change_time_nxt;
    since_press  = now - press_time_r;
    if (since_change > deb_t && level != stable_r) begin
      stable_nxt = level;
      if (!level) begin
        press_time_nxt = now;
        warn_done_nxt  = 1'b0;
      end else if (since_press < cmax_t) begin
        if (click_total_r != CLICK_SAT) begin
          click_total_nxt = click_total_r + 1'b1;
        end
        last_click_nxt = now;
      end
    end

    // click window closed
    since_click = now - last_click_nxt;
    if (click_total_nxt != '0 && since_click >= cwin_t) begin
      case (click_total_nxt)
        CLICK_W'(1): ev = EV_CLICK;
        CLICK_W'(2): ev = EV_DOUBLE;
        default:     ev = EV_TRIPLE;
      endcase
      click_total_nxt = '0;
      last_click_nxt  = '0;
    end

    // hold events override clicks
    held = now - press_time_nxt;
    if (!stable_nxt && press_time_nxt != '0) begin
      if (held >= lhold_t && warn_done_nxt) begin
        ev             = EV_LONG;
        press_time_nxt = '0;
      end else if (held >= hwarn_t && !warn_done_nxt) begin
        warn_done_nxt = 1'b1;
        ev            = EV_WARN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r      <= 1'b1;
      prev_raw_r    <= 1'b1;
      change_time_r <= '0;
      press_time_r  <= '0;
      last_click_r  <= '0;
      click_total_r <= '0;
      warn_done_r   <= 1'b0;
    end else if (step_en) begin
      stable_r      <= stable_nxt;
      prev_raw_r    <= prev_raw_nxt;
      change_time_r <= change_time_nxt;
      press_time_r  <= press_time_nxt;
      last_click_r  <= last_click_nxt;
      click_total_r <= click_total_nxt;
      warn_done_r   <= warn_done_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/button_click_hold_classifier_core.sv
// button click / hold classifier: poll items in, one event code out per poll
// each poll passes through the input register, then its event through the result register
// one poll per cycle unless stalled; state update is one compare/subtract pass
// output register decouples the sides so a poll is taken while a result waits
// reset (rst_n low, synchronous): pipeline empty, state and config registers at defaults
// depends on bcc_pkg, bcc_if, bcc_engine and the macros header
`timescale 1ns / 1ps
`default_nettype none
`include "button_click_hold_classifier_core_macros.svh"

module button_click_hold_classifier_core
  import bcc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bcc_in_if.sink                     in_chan,
  bcc_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  bcc_cfg_t             cfg_r;
  logic                 s1_v_r;
  logic                 s1_level_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic                 out_v_r;
  ev_code_t             out_ev_r;
  ev_code_t             ev;
  logic                 s1_adv;
  logic                 in_take;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= DEBOUNCE_RST;
      cfg_r.click_max_ms    <= CLICK_MAX_RST;
      cfg_r.click_window_ms <= CLICK_WIN_RST;
      cfg_r.hold_warning_ms <= HOLD_WARN_RST;
      cfg_r.long_hold_ms    <= LONG_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEBOUNCE:  cfg_r.debounce_ms     <= cfg_wdata;
        CFG_CLICK_MAX: cfg_r.click_max_ms    <= cfg_wdata;
        CFG_CLICK_WIN: cfg_r.click_window_ms <= cfg_wdata;
        CFG_HOLD_WARN: cfg_r.hold_warning_ms <= cfg_wdata;
        CFG_LONG_HOLD: cfg_r.long_hold_ms    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_adv         = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready  = !s1_v_r || s1_adv;
  assign in_take        = in_chan.valid && in_chan.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level_r <= in_chan.button_level;
      s1_now_r   <= in_chan.now_ms[TIME_BITS-1:0];
    end
  end

  bcc_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .step_en (s1_adv),
    .level   (s1_level_r),
    .now     (s1_now_r),
    .ev      (ev)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ev_r <= ev;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.event_code = out_ev_r;

  `BCC_ASSERT_NOW(a_stall_blocks_input, s1_v_r && out_v_r && !out_chan.ready, !in_chan.ready, "input taken while pipeline full")
  `BCC_ASSERT_NEXT(a_adv_fills_output, s1_adv, out_v_r, "advanced poll produced no result")
  `BCC_ASSERT_NOW(a_ev_range, out_v_r, out_ev_r <= EV_LONG, "event code out of range")
  `BCC_ASSERT_NEXT(a_take_fills_stage, in_take, s1_v_r, "accepted poll lost from input stage")

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// self-checking bench for the button click / hold classifier core
// drives poll transactions and config writes, predicts each event code
// depends on bcc_pkg, bcc_if and button_click_hold_classifier_core
`timescale 1ns / 1ps

module tb_top;
  import bcc_pkg::*;

  localparam int unsigned CLK_HALF   = 6;
  localparam int unsigned RST_CYCLES = 6;
  localparam int unsigned TIMEOUT_NS = 5_000_000;
  localparam int unsigned SEG_POLLS  = 8;
  localparam int unsigned NUM_SEGS   = 8;
  localparam int unsigned BURST_TAPS = 258;
  localparam int unsigned SHOW_MAX   = 10;
  localparam int unsigned DRAIN_CYC  = 6;

  localparam logic [CFG_ADDR_W-1:0] CFG_LAST_IDX = '1;

  typedef enum int unsigned {
    PACE_FULL,
    PACE_SRC_GAPS,
    PACE_SINK_STALLS,
    PACE_BOTH
  } pace_t;

  typedef struct packed {
    logic             lvl;
    logic [NOW_W-1:0] t;
    logic             pinned;
    ev_code_t         ev;
  } poll_row_t;

  // pinned rows carry an event readable straight from the reset settings
  localparam poll_row_t DIRECTED_POLLS [24] = '{
    '{1'b1, 32'd0,          1'b1, EV_NONE},
    '{1'b0, 32'd100,        1'b1, EV_NONE},
    '{1'b0, 32'd131,        1'b1, EV_NONE},
    '{1'b1, 32'd200,        1'b1, EV_NONE},
    '{1'b1, 32'd231,        1'b0, EV_NONE},
    '{1'b1, 32'd531,        1'b1, EV_CLICK},
    '{1'b0, 32'd1000,       1'b0, EV_NONE},
    '{1'b0, 32'd1031,       1'b0, EV_NONE},
    '{1'b0, 32'd6031,       1'b1, EV_WARN},
    '{1'b0, 32'd10031,      1'b1, EV_LONG},
    '{1'b0, 32'd20000,      1'b1, EV_NONE},
    '{1'b1, 32'd20000,      1'b0, EV_NONE},
    '{1'b1, 32'd20031,      1'b0, EV_NONE},
    '{1'b0, 32'd30000,      1'b0, EV_NONE},
    '{1'b0, 32'd30031,      1'b0, EV_NONE},
    '{1'b0, 32'd50000,      1'b1, EV_WARN},
    '{1'b0, 32'd50001,      1'b1, EV_LONG},
    '{1'b1, 32'd60000,      1'b0, EV_NONE},
    '{1'b1, 32'd60031,      1'b0, EV_NONE},
    '{1'b0, 32'hFFFF_FF00,  1'b0, EV_NONE},
    '{1'b0, 32'h0000_0000,  1'b0, EV_NONE},
    '{1'b0, 32'hFFFF_FFFF,  1'b1, EV_NONE},
    '{1'b1, 32'h5555_5555,  1'b0, EV_NONE},
    '{1'b1, 32'hAAAA_AAAA,  1'b0, EV_NONE}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;

  bcc_in_if  poll_bus ();
  bcc_out_if ev_bus ();

  button_click_hold_classifier_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (poll_bus),
    .out_chan  (ev_bus),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // classifier state mirror
  bcc_cfg_t         cfg_model;
  logic             db_level;
  logic             raw_last;
  logic [NOW_W-1:0] raw_change_t;
  logic [NOW_W-1:0] press_start_t;
  logic [NOW_W-1:0] last_tap_t;
  logic [CLICK_W-1:0] tap_count;
  logic             warned;

  ev_code_t         ev_expect_q [$];
  ev_code_t         want_ev;
  int unsigned      mismatches;
  int unsigned      polls_sent;
  int unsigned      in_idle_pct;
  int unsigned      out_stall_pct;
  logic [NOW_W-1:0] t_now;

  initial begin
    clk = 1'b0;
  end

  always #(CLK_HALF) clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top failed");
    $finish;
  end

  function automatic ev_code_t classify_poll(input logic lvl, input logic [NOW_W-1:0] t);
    ev_code_t         ev;
    logic [NOW_W-1:0] dt;
    ev = EV_NONE;
    if (lvl != raw_last) begin
      raw_last     = lvl;
      raw_change_t = t;
    end
    dt = t - raw_change_t;
    if (dt > NOW_W'(cfg_model.debounce_ms) && lvl != db_level) begin
      db_level = lvl;
      dt = t - press_start_t;
      if (!db_level) begin
        press_start_t = t;
        warned        = 1'b0;
      end else if (dt < NOW_W'(cfg_model.click_max_ms)) begin
        if (tap_count != CLICK_SAT) tap_count = tap_count + 1'b1;
        last_tap_t = t;
      end
    end
    dt = t - last_tap_t;
    if (tap_count != '0 && dt >= NOW_W'(cfg_model.click_window_ms)) begin
      if (tap_count == CLICK_W'(1)) begin
        ev = EV_CLICK;
      end else if (tap_count == CLICK_W'(2)) begin
        ev = EV_DOUBLE;
      end else begin
        ev = EV_TRIPLE;
      end
      tap_count  = '0;
      last_tap_t = '0;
    end
    // a zero press start means hold tracking is off
    if (!db_level && press_start_t != '0) begin
      dt = t - press_start_t;
      if (dt >= NOW_W'(cfg_model.long_hold_ms) && warned) begin
        ev            = EV_LONG;
        press_start_t = '0;
      end else if (dt >= NOW_W'(cfg_model.hold_warning_ms) && !warned) begin
        warned = 1'b1;
        ev     = EV_WARN;
      end
    end
    return ev;
  endfunction

  function automatic bcc_cfg_t make_cfg(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] cm,
                                        input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] hw,
                                        input logic [CFG_W-1:0] lh);
    bcc_cfg_t c;
    c.debounce_ms     = db;
    c.click_max_ms    = cm;
    c.click_window_ms = win;
    c.hold_warning_ms = hw;
    c.long_hold_ms    = lh;
    return c;
  endfunction

  function automatic logic [CFG_W-1:0] rand_reg(input int unsigned small_max);
    if ($urandom_range(0, 3) == 0) return CFG_W'($urandom_range(0, 65535));
    return CFG_W'($urandom_range(0, small_max));
  endfunction

  task automatic set_pace(input pace_t p);
    in_idle_pct   = (p == PACE_SRC_GAPS) ? 81 : (p == PACE_BOTH) ? 21 : 0;
    out_stall_pct = (p == PACE_SINK_STALLS) ? 81 : (p == PACE_BOTH) ? 21 : 0;
  endtask

  task automatic send_poll(input logic lvl, input logic [NOW_W-1:0] t,
                           input logic pinned = 1'b0, input ev_code_t pinned_ev = EV_NONE);
    ev_code_t pred;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      poll_bus.valid <= 1'b0;
      @(posedge clk);
    end
    poll_bus.valid        <= 1'b1;
    poll_bus.button_level <= lvl;
    poll_bus.now_ms       <= t;
    do @(posedge clk); while (!poll_bus.ready);
    pred = classify_poll(lvl, t);
    ev_expect_q.push_back(pinned ? pinned_ev : pred);
    polls_sent++;
  endtask

  task automatic wait_idle();
    poll_bus.valid <= 1'b0;
    while (ev_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DEBOUNCE:  cfg_model.debounce_ms     = val;
      CFG_CLICK_MAX: cfg_model.click_max_ms    = val;
      CFG_CLICK_WIN: cfg_model.click_window_ms = val;
      CFG_HOLD_WARN: cfg_model.hold_warning_ms = val;
      CFG_LONG_HOLD: cfg_model.long_hold_ms    = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_cfg(input bcc_cfg_t c);
    write_reg(CFG_DEBOUNCE, c.debounce_ms);
    write_reg(CFG_CLICK_MAX, c.click_max_ms);
    // unmapped index, must leave every register alone
    write_reg(CFG_ADDR_W'($urandom_range(CFG_LONG_HOLD + 1, CFG_LAST_IDX)),
              CFG_W'($urandom_range(0, 65535)));
    write_reg(CFG_CLICK_WIN, c.click_window_ms);
    write_reg(CFG_HOLD_WARN, c.hold_warning_ms);
    write_reg(CFG_LONG_HOLD, c.long_hold_ms);
    cfg_we <= 1'b0;
  endtask

  // one level held for at least dur ms, optionally preceded by contact bounce
  task automatic hold_level(input logic lvl, input int unsigned dur, input logic bouncy);
    int unsigned elapsed;
    int unsigned stp;
    if (bouncy && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        t_now += $urandom_range(0, 2);
        send_poll(1'($urandom_range(0, 1)), t_now);
      end
    end
    t_now += $urandom_range(0, 3);
    send_poll(lvl, t_now);
    elapsed = 0;
    while (elapsed < dur) begin
      stp = $urandom_range(1, dur / 3 + 1);
      elapsed += stp;
      t_now   += stp;
      send_poll(lvl, t_now);
    end
  endtask

  task automatic run_gesture();
    int unsigned db;
    int unsigned cm;
    int unsigned win;
    int unsigned hw;
    int unsigned lh;
    db  = cfg_model.debounce_ms;
    cm  = cfg_model.click_max_ms;
    win = cfg_model.click_window_ms;
    hw  = cfg_model.hold_warning_ms;
    lh  = cfg_model.long_hold_ms;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        repeat ($urandom_range(1, 4)) begin
          hold_level(1'b0, db + 1 + $urandom_range(0, cm + cm / 4), 1'b1);
          hold_level(1'b1, db + 1 + $urandom_range(0, win), 1'b1);
        end
        hold_level(1'b1, db + 1 + win + $urandom_range(0, win), 1'b0);
      end
      5, 6: begin
        hold_level(1'b0, db + 1 + $urandom_range(0, lh + lh / 2 + hw), 1'b1);
        hold_level(1'b1, db + 1 + $urandom_range(0, 2 * win), 1'b1);
      end
      7, 8: begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0) begin
            t_now = $urandom();
          end else begin
            t_now += $urandom_range(0, 3);
          end
          send_poll(1'($urandom_range(0, 1)), t_now);
        end
      end
      default: begin
        // move close to the timestamp wrap
        t_now = {NOW_W{1'b1}} - $urandom_range(0, db + cm);
      end
    endcase
  endtask

  always @(posedge clk) begin
    ev_bus.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && ev_bus.valid && ev_bus.ready) begin
      if (ev_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("event %0d arrived with no poll pending", ev_bus.event_code);
      end else begin
        want_ev = ev_expect_q.pop_front();
        if (ev_bus.event_code !== want_ev) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("event mismatch: expected %0d got %0d", want_ev, ev_bus.event_code);
        end
      end
    end
  end

  initial begin
    int          i;
    int          seg;
    int unsigned seg_start;
    bcc_cfg_t    nxt;

    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_addr              = CFG_DEBOUNCE;
    cfg_wdata             = '0;
    poll_bus.valid        = 1'b0;
    poll_bus.button_level = 1'b1;
    poll_bus.now_ms       = '0;
    mismatches            = 0;
    polls_sent            = 0;
    cfg_model             = make_cfg(DEBOUNCE_RST, CLICK_MAX_RST, CLICK_WIN_RST,
                                     HOLD_WARN_RST, LONG_HOLD_RST);
    db_level              = 1'b1;
    raw_last              = 1'b1;
    raw_change_t          = '0;
    press_start_t         = '0;
    last_tap_t            = '0;
    tap_count             = '0;
    warned                = 1'b0;
    set_pace(PACE_FULL);

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: click, hold warning, long hold, zero press start, wrap
    for (i = 0; i < $size(DIRECTED_POLLS); i++) begin
      send_poll(DIRECTED_POLLS[i].lvl, DIRECTED_POLLS[i].t,
                DIRECTED_POLLS[i].pinned, DIRECTED_POLLS[i].ev);
      t_now = DIRECTED_POLLS[i].t;
    end

    for (seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg)
        0: nxt = make_cfg(16'd3, 16'd40, 16'd25, 16'd80, 16'd150);
        1: nxt = make_cfg(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        2: nxt = make_cfg(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: nxt = make_cfg(rand_reg(20), rand_reg(200), rand_reg(200),
                                rand_reg(400), rand_reg(700));
      endcase
      wait_idle();
      program_cfg(nxt);
      set_pace(pace_t'(seg % 4));
      seg_start = polls_sent;
      while (polls_sent - seg_start < SEG_POLLS) run_gesture();
    end

    // long tap burst so the click count saturates
    wait_idle();
    program_cfg(make_cfg(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    set_pace(PACE_FULL);
    t_now += 1;
    send_poll(1'b1, t_now);
    t_now += 1;
    send_poll(1'b1, t_now);
    repeat (BURST_TAPS) begin
      t_now += 1;
      send_poll(1'b0, t_now);
      t_now += 1;
      send_poll(1'b0, t_now);
      t_now += 1;
      send_poll(1'b1, t_now);
      t_now += 1;
      send_poll(1'b1, t_now);
    end
    t_now += 32'd65536;
    send_poll(1'b1, t_now);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
